@@ hdl/rau_pkg.sv @@
`default_nettype none
package rau_pkg;
    localparam int DEF_WIDTH = 32;
    localparam int CMD_W = 3;
    localparam int ERR_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CMP = 3'd4;

    localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_ZERO = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVF  = 2'd2;

    typedef struct packed {
        logic [2:0]   command;
        logic [31:0]  a_num;
        logic [31:0]  a_den;
        logic [31:0]  b_num;
        logic [31:0]  b_den;
    } in_word_t;

    typedef struct packed {
        logic [31:0] res_num;
        logic [30:0] res_den;
        logic        less;
        logic        equal;
        logic        greater;
        logic [1:0]  error;
    } out_word_t;

    // Classified job passed from front to back
    typedef struct packed {
        logic        skip;
        logic [1:0]  error;
        logic        is_cmp;
        logic        sa;
        logic        sb;
        logic [2:0]  command;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] bn;
        logic [31:0] bd;
    } job_t;
endpackage
`default_nettype wire

@@ hdl/rau_front.sv @@
`default_nettype none
module rau_front #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    input  rau_pkg::in_word_t   in_word,
    output logic                job_valid,
    input  wire                 job_ready,
    output rau_pkg::job_t       job
);
    localparam int DEPTH = 2;

    rau_pkg::job_t q_reg [DEPTH];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    rau_pkg::job_t cls;

    logic [WIDTH-1:0] an_w, ad_w, bn_w, bd_w;
    logic [WIDTH:0]   an_m, ad_m, bn_m, bd_m;

    function automatic logic [WIDTH:0] mag(input logic [WIDTH-1:0] v);
        logic [WIDTH:0] e;
        e = {1'b0, v};
        mag = v[WIDTH-1] ? (({1'b1, {WIDTH{1'b0}}}) - e) : e;
    endfunction

    always_comb begin
        an_w = in_word.a_num[WIDTH-1:0];
        ad_w = in_word.a_den[WIDTH-1:0];
        bn_w = in_word.b_num[WIDTH-1:0];
        bd_w = in_word.b_den[WIDTH-1:0];
        an_m = mag(an_w);
        ad_m = mag(ad_w);
        bn_m = mag(bn_w);
        bd_m = mag(bd_w);
        cls.command = in_word.command;
        cls.an = 32'(an_m);
        cls.ad = 32'(ad_m);
        cls.bn = 32'(bn_m);
        cls.bd = 32'(bd_m);
        cls.sa = an_w[WIDTH-1] ^ ad_w[WIDTH-1];
        cls.sb = bn_w[WIDTH-1] ^ bd_w[WIDTH-1];
        cls.is_cmp = in_word.command == rau_pkg::CMD_CMP;
        cls.skip = 1'b0;
        cls.error = rau_pkg::ERR_OK;
        if (in_word.command > rau_pkg::CMD_CMP) begin
            cls.skip = 1'b1;
        end else if (ad_m == '0 || bd_m == '0
                     || (in_word.command == rau_pkg::CMD_DIV && bn_m == '0)) begin
            cls.skip = 1'b1;
            cls.error = rau_pkg::ERR_ZERO;
        end
    end

    assign in_ready  = cnt_reg != 2'(DEPTH);
    assign job_valid = cnt_reg != 2'd0;
    assign job       = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            q_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (in_valid && in_ready) begin
                wp_reg <= ~wp_reg;
            end
            if (job_valid && job_ready) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(job_valid && job_ready);
        end
    end
endmodule
`default_nettype wire

@@ hdl/rau_back.sv @@
`default_nettype none
module rau_back #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 job_valid,
    output logic                job_ready,
    input  rau_pkg::job_t       job,
    output logic                out_valid,
    input  wire                 out_ready,
    output rau_pkg::out_word_t  out_word
);
    localparam int DW = 2 * WIDTH + 1;
    localparam int CW = $clog2(DW + 1);
    localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_SUM = 4'd2, S_GCD = 4'd3,
                           S_DIVN = 4'd4, S_DIVD = 4'd5, S_CHK = 4'd6, S_OUT = 4'd7,
                           S_GLD = 4'd8;

    logic [3:0]        st_reg;
    rau_pkg::job_t     j_reg;
    logic [2*WIDTH-1:0] x_reg, y_reg, p_reg;
    logic [DW-1:0]     num_reg, den_reg, g_reg, ga_reg, gb_reg;
    logic [DW-1:0]     q_reg, r_reg;
    logic              neg_reg;
    logic [CW-1:0]     bit_reg, gk_reg;
    logic [1:0]        mstep_reg;
    rau_pkg::out_word_t o_reg;
    rau_pkg::out_word_t skip_word;
    logic [WIDTH-1:0]  ma, mb;
    logic [2*WIDTH-1:0] mp;
    logic [DW:0]       rtry;
    logic [DW-1:0]     lim, rdiv, qnext, rnext;
    logic              rbit;
    logic [WIDTH-1:0]  wn;

    assign job_ready = st_reg == S_IDLE;
    assign out_valid = st_reg == S_OUT;
    assign out_word  = o_reg;

    always_comb begin
        skip_word = '0;
        skip_word.error = job.error;
    end

    always_comb begin
        case (mstep_reg)
            2'd0: begin ma = j_reg.an[WIDTH-1:0]; mb = j_reg.bd[WIDTH-1:0]; end
            2'd1: begin ma = j_reg.bn[WIDTH-1:0]; mb = j_reg.ad[WIDTH-1:0]; end
            2'd2: begin
                ma = j_reg.ad[WIDTH-1:0];
                mb = (j_reg.command == rau_pkg::CMD_DIV) ? j_reg.bn[WIDTH-1:0]
                                                          : j_reg.bd[WIDTH-1:0];
            end
            default: begin ma = j_reg.an[WIDTH-1:0]; mb = j_reg.bn[WIDTH-1:0]; end
        endcase
        mp = (2*WIDTH)'(ma) * (2*WIDTH)'(mb);
    end
    // A magnitude of 2^(WIDTH-1)... WIDTH bits hold it since mag <= 2^(WIDTH-1)

    assign rdiv  = (st_reg == S_DIVN) ? num_reg : den_reg;
    assign rbit  = rdiv[bit_reg - CW'(1)];
    assign rtry  = {r_reg, rbit} - {1'b0, g_reg};
    assign qnext = {q_reg[DW-2:0], ~rtry[DW]};
    assign rnext = rtry[DW] ? DW'({r_reg, rbit}) : rtry[DW-1:0];
    assign lim   = DW'(1) << (WIDTH - 1);
    assign wn    = WIDTH'(num_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
        end else begin
            case (st_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        j_reg <= job;
                        mstep_reg <= 2'd0;
                        if (job.skip) begin
                            o_reg <= skip_word;
                            st_reg <= S_OUT;
                        end else begin
                            o_reg <= '0;
                            st_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    mstep_reg <= mstep_reg + 2'd1;
                    case (mstep_reg)
                        2'd0: x_reg <= mp;
                        2'd1: y_reg <= mp;
                        2'd2: p_reg <= mp;
                        default: begin
                            num_reg <= DW'(mp);
                            st_reg <= S_SUM;
                        end
                    endcase
                end
                S_SUM: begin
                    den_reg <= DW'(p_reg);
                    if (j_reg.is_cmp) begin
                        if (j_reg.sa != j_reg.sb && (x_reg != '0 || y_reg != '0)) begin
                            o_reg.less    <= j_reg.sa && (x_reg != '0) || (x_reg == '0 && !j_reg.sb);
                            o_reg.greater <= !(j_reg.sa && (x_reg != '0) || (x_reg == '0 && !j_reg.sb));
                        end else if (x_reg == y_reg) begin
                            o_reg.equal <= 1'b1;
                        end else begin
                            o_reg.less    <= (x_reg < y_reg) ^ j_reg.sa;
                            o_reg.greater <= (x_reg > y_reg) ^ j_reg.sa;
                        end
                        st_reg <= S_OUT;
                    end else begin
                        if (j_reg.command == rau_pkg::CMD_ADD || j_reg.command == rau_pkg::CMD_SUB) begin
                            if (j_reg.sa == (j_reg.sb ^ (j_reg.command == rau_pkg::CMD_SUB))) begin
                                num_reg <= DW'(x_reg) + DW'(y_reg);
                                neg_reg <= j_reg.sa;
                            end else if (x_reg >= y_reg) begin
                                num_reg <= DW'(x_reg - y_reg);
                                neg_reg <= j_reg.sa;
                            end else begin
                                num_reg <= DW'(y_reg - x_reg);
                                neg_reg <= !j_reg.sa;
                            end
                        end else if (j_reg.command == rau_pkg::CMD_MUL) begin
                            neg_reg <= j_reg.sa ^ j_reg.sb;
                        end else begin
                            num_reg <= DW'(x_reg);
                            neg_reg <= j_reg.sa ^ j_reg.sb;
                        end
                        st_reg <= S_GLD;
                    end
                end
                S_GLD: begin
                    ga_reg <= num_reg;
                    gb_reg <= den_reg;
                    gk_reg <= '0;
                    st_reg <= S_GCD;
                end
                S_GCD: begin
                    // strip shared twos, then halve and subtract odd pairs
                    if (ga_reg == '0) begin
                        g_reg   <= gb_reg << gk_reg;
                        r_reg   <= '0;
                        q_reg   <= '0;
                        bit_reg <= CW'(DW);
                        st_reg  <= S_DIVN;
                    end else if (!ga_reg[0] && !gb_reg[0]) begin
                        ga_reg <= ga_reg >> 1;
                        gb_reg <= gb_reg >> 1;
                        gk_reg <= gk_reg + CW'(1);
                    end else if (!ga_reg[0]) begin
                        ga_reg <= ga_reg >> 1;
                    end else if (!gb_reg[0]) begin
                        gb_reg <= gb_reg >> 1;
                    end else if (ga_reg >= gb_reg) begin
                        ga_reg <= (ga_reg - gb_reg) >> 1;
                    end else begin
                        gb_reg <= (gb_reg - ga_reg) >> 1;
                    end
                end
                S_DIVN, S_DIVD: begin
                    if (bit_reg == CW'(1)) begin
                        bit_reg <= CW'(DW);
                        r_reg <= '0;
                        q_reg <= '0;
                        if (st_reg == S_DIVN) begin
                            num_reg <= qnext;
                            st_reg <= S_DIVD;
                        end else begin
                            den_reg <= qnext;
                            st_reg <= S_CHK;
                        end
                    end else begin
                        r_reg <= rnext;
                        q_reg <= qnext;
                        bit_reg <= bit_reg - CW'(1);
                    end
                end
                S_CHK: begin
                    if (den_reg > lim - DW'(1) || num_reg > (neg_reg ? lim : lim - DW'(1))) begin
                        o_reg.error <= rau_pkg::ERR_OVF;
                    end else begin
                        o_reg.res_num <= 32'($signed(neg_reg ? (WIDTH'(0) - wn) : wn));
                        o_reg.res_den <= 31'(den_reg);
                    end
                    st_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_ready) begin
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hdl/rational_arith_unit.sv @@
`default_nettype none
// From input accept to result valid: an error or unused command goes from the
// queue straight to the output, compare passes the multiply and sum states, and
// arithmetic commands add a binary gcd, two quotient divisions by the gcd that
// run one bit per cycle, and an overflow check. The back takes one word at a
// time, the next once idle after a result is taken; a two-entry queue feeds it.
// Reset: synchronous active-low aresetn clears queue and sequencer.
module rational_arith_unit #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  rau_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output rau_pkg::out_word_t  m_data
);
    logic          job_valid, job_ready;
    rau_pkg::job_t job;

    rau_front #(.WIDTH(WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_word(s_data),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    rau_back #(.WIDTH(WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .out_valid(m_valid), .out_ready(m_ready), .out_word(m_data)
    );

`ifndef NO_ASSERTIONS
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_data.less, m_data.equal, m_data.greater}) <= 1)
        else $error("more than one compare flag");
    a_err_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.error != rau_pkg::ERR_OK) |-> m_data.res_den == '0)
        else $error("denominator nonzero on error");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_data))
        else $error("result dropped while stalled");
`endif
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_WORDS = 850;
    localparam longint CYCLE_LIMIT = 6_000_000;
    localparam longint unsigned HALF = 64'h8000_0000;
    localparam logic [31:0] S_MIN = 32'h8000_0000;
    localparam logic [31:0] S_MAX = 32'h7fff_ffff;
    localparam logic [31:0] FIB45 = 32'd1134903170;
    localparam logic [31:0] FIB46 = 32'd1836311903;

    typedef struct {
        bit        neg;
        longint unsigned mag;
    } smag_t;

    typedef struct {
        rau_pkg::in_word_t  word;
        bit                 known;
        rau_pkg::out_word_t result;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    rau_pkg::in_word_t  s_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    rau_pkg::out_word_t m_data;

    rau_pkg::out_word_t  expected_q[$];
    stim_row_t  stim_rows[$];
    int         fail_count = 0;
    int         checked_count = 0;
    int         sent_count;
    longint     cycle_count = 0;

    rational_arith_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic smag_t to_smag(logic [31:0] v);
        smag_t r;
        r.neg = v[31];
        r.mag = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
        return r;
    endfunction

    function automatic smag_t signed_sum(smag_t x, smag_t y);
        smag_t r;
        if (x.neg == y.neg) begin
            r.neg = x.neg;
            r.mag = x.mag + y.mag;
        end else if (x.mag >= y.mag) begin
            r.neg = x.neg;
            r.mag = x.mag - y.mag;
        end else begin
            r.neg = y.neg;
            r.mag = y.mag - x.mag;
        end
        if (r.mag == 0) r.neg = 1'b0;
        return r;
    endfunction

    function automatic rau_pkg::out_word_t predict_fraction(rau_pkg::in_word_t w);
        rau_pkg::out_word_t r;
        smag_t an, ad, bn, bd, x, y, num;
        bit sa, sb;
        longint unsigned den, g, p, q, t;
        r = '0;
        an = to_smag(w.a_num);
        ad = to_smag(w.a_den);
        bn = to_smag(w.b_num);
        bd = to_smag(w.b_den);
        sa = an.neg ^ ad.neg;
        sb = bn.neg ^ bd.neg;
        if (w.command > rau_pkg::CMD_CMP) return r;
        if (ad.mag == 0 || bd.mag == 0 || (w.command == rau_pkg::CMD_DIV && bn.mag == 0)) begin
            r.error = rau_pkg::ERR_ZERO;
            return r;
        end
        x.mag = an.mag * bd.mag;
        x.neg = sa && x.mag != 0;
        y.mag = bn.mag * ad.mag;
        y.neg = sb && y.mag != 0;
        if (w.command == rau_pkg::CMD_CMP) begin
            if (x.neg != y.neg) begin
                r.less = x.neg;
                r.greater = !x.neg;
            end else if (x.mag == y.mag) begin
                r.equal = 1'b1;
            end else begin
                r.greater = (x.mag > y.mag) ^ x.neg;
                r.less = !r.greater;
            end
            return r;
        end
        den = ad.mag * bd.mag;
        case (w.command)
            rau_pkg::CMD_ADD: num = signed_sum(x, y);
            rau_pkg::CMD_SUB: begin
                y.neg = y.mag != 0 && !y.neg;
                num = signed_sum(x, y);
            end
            rau_pkg::CMD_MUL: begin
                num.mag = an.mag * bn.mag;
                num.neg = (sa ^ sb) && num.mag != 0;
            end
            default: begin
                num.mag = an.mag * bd.mag;
                num.neg = (sa ^ sb) && num.mag != 0;
                den = ad.mag * bn.mag;
            end
        endcase
        p = num.mag;
        q = den;
        while (q != 0) begin
            t = p % q;
            p = q;
            q = t;
        end
        g = p;
        num.mag = num.mag / g;
        den = den / g;
        if (den > HALF - 1 || num.mag > (num.neg ? HALF : HALF - 1)) begin
            r.error = rau_pkg::ERR_OVF;
            return r;
        end
        r.res_num = num.neg ? 32'(0 - num.mag) : 32'(num.mag);
        r.res_den = 31'(den);
        return r;
    endfunction

    function automatic rau_pkg::out_word_t make_result(logic [31:0] n, logic [30:0] d,
                                                       logic [2:0] flags, logic [1:0] e);
        rau_pkg::out_word_t r;
        r.res_num = n;
        r.res_den = d;
        {r.less, r.equal, r.greater} = flags;
        r.error = e;
        return r;
    endfunction

    function automatic rau_pkg::in_word_t make_word(logic [2:0] c, logic [31:0] an,
                                                    logic [31:0] ad, logic [31:0] bn,
                                                    logic [31:0] bd);
        rau_pkg::in_word_t w;
        w.command = c;
        w.a_num = an;
        w.a_den = ad;
        w.b_num = bn;
        w.b_den = bd;
        return w;
    endfunction

    task automatic add_row(rau_pkg::in_word_t w, bit known, rau_pkg::out_word_t r);
        stim_row_t row;
        row.word = w;
        row.known = known;
        row.result = r;
        stim_rows.push_back(row);
    endtask

    function automatic logic [31:0] small_value(int lo);
        logic [31:0] v;
        v = 32'($urandom_range(lo, 63));
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    function automatic rau_pkg::in_word_t random_word();
        rau_pkg::in_word_t w;
        int pick;
        logic [31:0] p, q;
        pick = $urandom_range(0, 99);
        p = $urandom;
        q = $urandom;
        w.command = 3'($urandom_range(0, 3));
        if (pick < 55) begin
            w.a_num = small_value(0);
            w.a_den = small_value(1);
            w.b_num = small_value(0);
            w.b_den = small_value(1);
        end else if (pick < 75) begin
            w = make_word(rau_pkg::CMD_CMP, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 85) begin
            if ($urandom_range(0, 1)) w = make_word(rau_pkg::CMD_MUL, p, q, q, p);
            else w = make_word(rau_pkg::CMD_DIV, p, q, p, q);
        end else if (pick < 93) begin
            w = make_word(3'($urandom_range(0, 4)), $urandom, $urandom, $urandom, $urandom);
            case ($urandom_range(0, 2))
                0: w.a_den = '0;
                1: w.b_den = '0;
                default: begin
                    w.command = rau_pkg::CMD_DIV;
                    w.b_num = '0;
                end
            endcase
        end else begin
            w = make_word(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom);
        end
        return w;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        fail_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    endtask

    task automatic send_word(rau_pkg::in_word_t w, rau_pkg::out_word_t want);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        expected_q.push_back(want);
        sent_count++;
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d words outstanding",
                     cycle_count, expected_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        int phase;
        phase = int'((cycle_count / 300) % 3);
        case (phase)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= (cycle_count % 7) < 3;
        endcase
    end

    always @(posedge aclk) begin
        rau_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word", m_data, 0);
            end else begin
                want = expected_q.pop_front();
                checked_count++;
                if (m_data.res_num !== want.res_num)
                    report_mismatch("res_num", m_data.res_num, want.res_num);
                if (m_data.res_den !== want.res_den)
                    report_mismatch("res_den", m_data.res_den, want.res_den);
                if (m_data.less !== want.less)
                    report_mismatch("less", m_data.less, want.less);
                if (m_data.equal !== want.equal)
                    report_mismatch("equal", m_data.equal, want.equal);
                if (m_data.greater !== want.greater)
                    report_mismatch("greater", m_data.greater, want.greater);
                if (m_data.error !== want.error)
                    report_mismatch("error", m_data.error, want.error);
            end
        end
    end

    initial begin
        int burst;
        int gap;
        int wait_count;
        rau_pkg::in_word_t w;
        rau_pkg::out_word_t want;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        sent_count = 0;

        add_row(make_word(rau_pkg::CMD_ADD, 1, 2, 1, 3), 1,
                make_result(5, 6, 3'b000, rau_pkg::ERR_OK));
        add_row(make_word(rau_pkg::CMD_SUB, 1, 2, 1, 3), 1,
                make_result(1, 6, 3'b000, rau_pkg::ERR_OK));
        add_row(make_word(rau_pkg::CMD_MUL, 2, 3, 3, 4), 1,
                make_result(1, 2, 3'b000, rau_pkg::ERR_OK));
        add_row(make_word(rau_pkg::CMD_DIV, 1, 2, 1, 4), 1,
                make_result(2, 1, 3'b000, rau_pkg::ERR_OK));
        add_row(make_word(rau_pkg::CMD_CMP, 1, 3, 1, 2), 1,
                make_result(0, 0, 3'b100, rau_pkg::ERR_OK));
        add_row(make_word(rau_pkg::CMD_CMP, 2, 4, 1, 2), 1,
                make_result(0, 0, 3'b010, rau_pkg::ERR_OK));
        add_row(make_word(rau_pkg::CMD_CMP, -1, 2, -1, 3), 0, '0);
        add_row(make_word(rau_pkg::CMD_ADD, 3, -4, 0, 1), 1,
                make_result(-3, 4, 3'b000, rau_pkg::ERR_OK));
        add_row(make_word(rau_pkg::CMD_SUB, 7, 3, 7, 3), 1,
                make_result(0, 1, 3'b000, rau_pkg::ERR_OK));
        add_row(make_word(rau_pkg::CMD_MUL, 0, 5, 3, 7), 1,
                make_result(0, 1, 3'b000, rau_pkg::ERR_OK));
        add_row(make_word(rau_pkg::CMD_ADD, 5, 0, 1, 2), 1,
                make_result(0, 0, 3'b000, rau_pkg::ERR_ZERO));
        add_row(make_word(rau_pkg::CMD_CMP, 5, 3, 1, 0), 1,
                make_result(0, 0, 3'b000, rau_pkg::ERR_ZERO));
        add_row(make_word(rau_pkg::CMD_DIV, 5, 3, 0, 7), 1,
                make_result(0, 0, 3'b000, rau_pkg::ERR_ZERO));
        add_row(make_word(3'd5, S_MAX, S_MIN, 1, 2), 1, '0);
        add_row(make_word(3'd6, -1, -1, -1, -1), 1, '0);
        add_row(make_word(3'd7, 0, 0, 0, 0), 1, '0);
        add_row(make_word(rau_pkg::CMD_MUL, S_MIN, S_MIN, S_MIN, S_MIN), 1,
                make_result(1, 1, 3'b000, rau_pkg::ERR_OK));
        add_row(make_word(rau_pkg::CMD_DIV, S_MAX, S_MAX, S_MAX, S_MAX), 1,
                make_result(1, 1, 3'b000, rau_pkg::ERR_OK));
        add_row(make_word(rau_pkg::CMD_CMP, S_MIN, 1, S_MAX, 1), 1,
                make_result(0, 0, 3'b100, rau_pkg::ERR_OK));
        add_row(make_word(rau_pkg::CMD_CMP, S_MAX, 1, S_MIN, -1), 0, '0);
        add_row(make_word(rau_pkg::CMD_CMP, S_MIN, -1, S_MIN, -1), 1,
                make_result(0, 0, 3'b010, rau_pkg::ERR_OK));
        add_row(make_word(rau_pkg::CMD_MUL, FIB46, FIB45, FIB46, FIB45), 1,
                make_result(0, 0, 3'b000, rau_pkg::ERR_OVF));
        add_row(make_word(rau_pkg::CMD_MUL, -FIB46, FIB45, FIB46, FIB45), 1,
                make_result(0, 0, 3'b000, rau_pkg::ERR_OVF));
        add_row(make_word(rau_pkg::CMD_ADD, -1, -1, -1, -1), 1,
                make_result(2, 1, 3'b000, rau_pkg::ERR_OK));
        add_row(make_word(rau_pkg::CMD_MUL, S_MIN, S_MAX, S_MAX, S_MIN), 0, '0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        burst = $urandom_range(1, 8);
        for (int i = 0; i < stim_rows.size() + RANDOM_WORDS; i++) begin
            if (i < stim_rows.size()) begin
                w = stim_rows[i].word;
                want = stim_rows[i].known ? stim_rows[i].result : predict_fraction(w);
            end else begin
                w = random_word();
                want = predict_fraction(w);
            end
            send_word(w, want);
            burst--;
            if (burst <= 0) begin
                burst = $urandom_range(1, 12);
                gap = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 160);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        s_valid <= 1'b0;

        wait_count = 0;
        while (expected_q.size() != 0) @(posedge aclk);
        while (wait_count < 20) begin
            @(posedge aclk);
            wait_count++;
        end

        $display("sent %0d words (%0d directed), checked %0d results",
                 sent_count, stim_rows.size(), checked_count);
        $display("covered add, sub, mul, div, compare, zero denominators, overflow, unused codes");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/rau_pkg.sv
hdl/rau_front.sv
hdl/rau_back.sv
hdl/rational_arith_unit.sv
tb/testbench.sv
